// ----- rtl/core/clock_buffer_frame_manager_top_defines.svh -----
// Assertion macros shared by the frame manager RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef CLOCK_BUFFER_FRAME_MANAGER_TOP_DEFINES_SVH
`define CLOCK_BUFFER_FRAME_MANAGER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define CBFM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");
`else
`define CBFM_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`ifndef ASSERT_OFF
`define CBFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define CBFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/core/cbfm_pkg.sv -----
// Shared types and codes of the buffer frame manager.
// No dependencies; used by the frame memory, sequencer and top level.
package cbfm_pkg;

	localparam int ADDR_W   = 6;
	localparam int FILE_W   = 8;
	localparam int PAGE_W   = 20;
	localparam int PINS_W   = 8;

	localparam logic [2:0] KIND_READ     = 3'd0;
	localparam logic [2:0] KIND_ALLOC    = 3'd1;
	localparam logic [2:0] KIND_UNPIN    = 3'd2;
	localparam logic [2:0] KIND_DISPOSE  = 3'd3;
	localparam logic [2:0] KIND_FLUSH    = 3'd4;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NO_FREE    = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [2:0] ST_NOT_PINNED = 3'd3;
	localparam logic [2:0] ST_PINNED     = 3'd4;
	localparam logic [2:0] ST_BAD_FRAME  = 3'd5;

	localparam logic [1:0] OP_NONE       = 2'd0;
	localparam logic [1:0] OP_WRITE_BACK = 2'd1;
	localparam logic [1:0] OP_READ_IN    = 2'd2;
	localparam logic [1:0] OP_RELEASE    = 2'd3;

	localparam logic [PINS_W-1:0] PIN_MAX = 8'hFF;
	localparam logic [5:0]        WB_LIMIT = 6'd32;

	typedef struct packed {
		logic              valid;
		logic              refb;
		logic              dirty;
		logic [PINS_W-1:0] pins;
		logic [FILE_W-1:0] file;
		logic [PAGE_W-1:0] page;
	} frame_entry_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		frame_entry_t      wdata;
	} mem_req_t;

endpackage

// ----- rtl/core/clock_buffer_frame_manager_top.sv -----
// Clock-sweep buffer frame manager, one request at a time; the next request is taken the cycle
// after the closing result is placed in the result register.
// Lookup reads and evaluates frames in turn (up to NUM_FRAMES); a read or alloc miss then
// sweeps the clock hand (up to 2*NUM_FRAMES steps); flush visits each frame until done or a
// pinned or bad frame ends it. Each frame step is a memory read state and an evaluate state
// on the single frame table port pair.
// Reset: all frames empty, clock hand at the last frame, output empty; no clearing pass.
module clock_buffer_frame_manager_top #(
	parameter int NUM_FRAMES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel: transfer when in_valid is high and in_stall is low
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  file_id,
	input  logic [19:0] page_number,
	input  logic        mark_dirty,
	// result channel: write-backs first, then one closing result with last set
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [4:0]  frame_index,
	output logic [1:0]  disk_op,
	output logic [7:0]  disk_file,
	output logic [19:0] disk_page,
	output logic        last
);
	// frame table access: the sequencer never reads and writes in one cycle,
	// so a read always returns the entry as left by the previous step
	cbfm_pkg::mem_req_t     mreq;
	cbfm_pkg::frame_entry_t rdata;

	cbfm_frame_mem #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.rdata (rdata)
	);

	// scan, sweep and flush sequencing plus the result register
	cbfm_seq #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.file_id    (file_id),
		.page_number(page_number),
		.mark_dirty (mark_dirty),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.frame_index(frame_index),
		.disk_op    (disk_op),
		.disk_file  (disk_file),
		.disk_page  (disk_page),
		.last       (last),
		.mreq       (mreq),
		.rdata      (rdata)
	);

endmodule

// ----- rtl/core/cbfm_frame_mem.sv -----
// Frame table memory: one write and one registered read port.
// Depends on cbfm_pkg; per-entry written flags give the reset value.
module cbfm_frame_mem #(
	parameter int NUM_FRAMES = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cbfm_pkg::mem_req_t    req,
	output cbfm_pkg::frame_entry_t rdata
);
	localparam int FW = $clog2(NUM_FRAMES);

	cbfm_pkg::frame_entry_t mem [NUM_FRAMES];
	cbfm_pkg::frame_entry_t rd_q;
	logic [NUM_FRAMES-1:0]  written_q;
	logic                   rd_written_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[FW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem[req.raddr[FW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (req.we) begin
				written_q[req.waddr[FW-1:0]] <= 1'b1;
			end
			if (req.re) begin
				rd_written_q <= written_q[req.raddr[FW-1:0]];
			end
		end
	end

	// an entry never written reads back with cleared status and file; the page is not cleared
	always_comb begin
		rdata = rd_q;
		if (!rd_written_q) begin
			rdata.valid = 1'b0;
			rdata.refb  = 1'b0;
			rdata.dirty = 1'b0;
			rdata.pins  = '0;
			rdata.file  = '0;
		end
	end

endmodule

// ----- rtl/core/cbfm_seq.sv -----
// Operation sequencer: tag scan, clock sweep, flush scan, result register.
// Depends on cbfm_pkg and the assertion macro header.
`include "clock_buffer_frame_manager_top_defines.svh"

module cbfm_seq #(
	parameter int NUM_FRAMES = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [2:0]             kind,
	input  logic [7:0]             file_id,
	input  logic [19:0]            page_number,
	input  logic                   mark_dirty,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [2:0]             status,
	output logic [4:0]             frame_index,
	output logic [1:0]             disk_op,
	output logic [7:0]             disk_file,
	output logic [19:0]            disk_page,
	output logic                   last,
	output cbfm_pkg::mem_req_t     mreq,
	input  cbfm_pkg::frame_entry_t rdata
);
	localparam int FW = $clog2(NUM_FRAMES);
	localparam int SW = $clog2(2 * NUM_FRAMES);
	localparam logic [FW-1:0] LAST_IDX  = FW'(NUM_FRAMES - 1);
	localparam logic [SW-1:0] LAST_STEP = SW'(2 * NUM_FRAMES - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LRD  = 3'd1;
	localparam logic [2:0] S_LEV  = 3'd2;
	localparam logic [2:0] S_SRD  = 3'd3;
	localparam logic [2:0] S_SEV  = 3'd4;
	localparam logic [2:0] S_FRD  = 3'd5;
	localparam logic [2:0] S_FEV  = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0]    state_q, state_d;
	logic [2:0]    kind_q;
	logic [7:0]    file_q;
	logic [19:0]   page_q;
	logic          mdirty_q;
	logic [FW-1:0] idx_q, idx_d;
	logic [FW-1:0] hand_q, hand_d;
	logic [SW-1:0] step_q, step_d;
	logic [5:0]    wbcnt_q, wbcnt_d;
	logic [2:0]    cl_status_q, cl_status_d;
	logic [4:0]    cl_frame_q, cl_frame_d;
	logic [1:0]    cl_op_q, cl_op_d;
	logic [7:0]    cl_file_q, cl_file_d;
	logic [19:0]   cl_page_q, cl_page_d;
	logic          push, push_last;
	logic [2:0]    p_status;
	logic [4:0]    p_frame;
	logic [1:0]    p_op;
	logic [7:0]    p_file;
	logic [19:0]   p_page;
	logic          out_free, in_acc, tag_hit, file_eq;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign file_eq  = (rdata.file == file_q);
	assign tag_hit  = rdata.valid && file_eq && (rdata.page == page_q);

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		hand_d      = hand_q;
		step_d      = step_q;
		wbcnt_d     = wbcnt_q;
		cl_status_d = cl_status_q;
		cl_frame_d  = cl_frame_q;
		cl_op_d     = cl_op_q;
		cl_file_d   = cl_file_q;
		cl_page_d   = cl_page_q;
		push        = 1'b0;
		push_last   = 1'b0;
		p_status    = cbfm_pkg::ST_OK;
		p_frame     = '0;
		p_op        = cbfm_pkg::OP_NONE;
		p_file      = '0;
		p_page      = '0;
		mreq        = '0;
		mreq.wdata  = rdata;

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					idx_d       = '0;
					wbcnt_d     = '0;
					cl_status_d = cbfm_pkg::ST_OK;
					cl_frame_d  = '0;
					cl_op_d     = cbfm_pkg::OP_NONE;
					cl_file_d   = '0;
					cl_page_d   = '0;
					case (kind) inside
						cbfm_pkg::KIND_FLUSH: state_d = S_FRD;
						cbfm_pkg::KIND_READ, cbfm_pkg::KIND_ALLOC,
						cbfm_pkg::KIND_UNPIN, cbfm_pkg::KIND_DISPOSE: state_d = S_LRD;
						default: state_d = S_FIN;
					endcase
				end
			end
			S_LRD: begin
				mreq.re    = 1'b1;
				mreq.raddr = cbfm_pkg::ADDR_W'(idx_q);
				state_d    = S_LEV;
			end
			S_LEV: begin
				mreq.waddr = cbfm_pkg::ADDR_W'(idx_q);
				if (tag_hit) begin
					state_d    = S_FIN;
					cl_frame_d = 5'(idx_q);
					case (kind_q)
						cbfm_pkg::KIND_READ: begin
							mreq.we         = 1'b1;
							mreq.wdata.refb = 1'b1;
							if (rdata.pins != cbfm_pkg::PIN_MAX) begin
								mreq.wdata.pins = rdata.pins + 8'd1;
							end
						end
						cbfm_pkg::KIND_UNPIN: begin
							if (rdata.pins == '0) begin
								cl_status_d = cbfm_pkg::ST_NOT_PINNED;
							end else begin
								mreq.we          = 1'b1;
								mreq.wdata.pins  = rdata.pins - 8'd1;
								mreq.wdata.dirty = rdata.dirty | mdirty_q;
							end
						end
						cbfm_pkg::KIND_DISPOSE: begin
							mreq.we          = 1'b1;
							mreq.wdata.valid = 1'b0;
							mreq.wdata.refb  = 1'b0;
							mreq.wdata.dirty = 1'b0;
							mreq.wdata.pins  = '0;
							mreq.wdata.file  = '0;
							cl_op_d          = cbfm_pkg::OP_RELEASE;
							cl_file_d        = file_q;
							cl_page_d        = page_q;
						end
						default: ;
					endcase
				end else if (idx_q != LAST_IDX) begin
					idx_d   = idx_q + 1'b1;
					state_d = S_LRD;
				end else begin
					case (kind_q)
						cbfm_pkg::KIND_UNPIN: begin
							cl_status_d = cbfm_pkg::ST_NOT_FOUND;
							state_d     = S_FIN;
						end
						cbfm_pkg::KIND_DISPOSE: begin
							cl_op_d   = cbfm_pkg::OP_RELEASE;
							cl_file_d = file_q;
							cl_page_d = page_q;
							state_d   = S_FIN;
						end
						default: begin
							step_d  = '0;
							state_d = S_SRD;
						end
					endcase
				end
			end
			S_SRD: begin
				hand_d     = (hand_q == LAST_IDX) ? '0 : hand_q + 1'b1;
				mreq.re    = 1'b1;
				mreq.raddr = cbfm_pkg::ADDR_W'(hand_d);
				state_d    = S_SEV;
			end
			S_SEV: begin
				mreq.waddr = cbfm_pkg::ADDR_W'(hand_q);
				if (rdata.valid && (rdata.refb || rdata.pins != '0)) begin
					if (rdata.refb) begin
						mreq.we         = 1'b1;
						mreq.wdata.refb = 1'b0;
					end
					if (step_q == LAST_STEP) begin
						cl_status_d = cbfm_pkg::ST_NO_FREE;
						state_d     = S_FIN;
					end else begin
						step_d  = step_q + 1'b1;
						state_d = S_SRD;
					end
				end else if (!(rdata.valid && rdata.dirty) || out_free) begin
					// victim: write back old tag if dirty, install new one
					if (rdata.valid && rdata.dirty) begin
						push     = 1'b1;
						p_frame  = 5'(hand_q);
						p_op     = cbfm_pkg::OP_WRITE_BACK;
						p_file   = rdata.file;
						p_page   = rdata.page;
					end
					mreq.we          = 1'b1;
					mreq.wdata.valid = 1'b1;
					mreq.wdata.refb  = 1'b1;
					mreq.wdata.dirty = 1'b0;
					mreq.wdata.pins  = 8'd1;
					mreq.wdata.file  = file_q;
					mreq.wdata.page  = page_q;
					cl_frame_d       = 5'(hand_q);
					if (kind_q == cbfm_pkg::KIND_READ) begin
						cl_op_d   = cbfm_pkg::OP_READ_IN;
						cl_file_d = file_q;
						cl_page_d = page_q;
					end
					state_d = S_FIN;
				end
			end
			S_FRD: begin
				mreq.re    = 1'b1;
				mreq.raddr = cbfm_pkg::ADDR_W'(idx_q);
				state_d    = S_FEV;
			end
			S_FEV: begin
				mreq.waddr = cbfm_pkg::ADDR_W'(idx_q);
				if (rdata.valid && file_eq && rdata.pins != '0) begin
					cl_status_d = cbfm_pkg::ST_PINNED;
					cl_frame_d  = 5'(idx_q);
					state_d     = S_FIN;
				end else if (!rdata.valid && file_eq) begin
					cl_status_d = cbfm_pkg::ST_BAD_FRAME;
					cl_frame_d  = 5'(idx_q);
					state_d     = S_FIN;
				end else if (!(rdata.valid && rdata.dirty && wbcnt_q < cbfm_pkg::WB_LIMIT
				               && file_eq) || out_free) begin
					if (rdata.valid && file_eq) begin
						if (rdata.dirty && wbcnt_q < cbfm_pkg::WB_LIMIT) begin
							push    = 1'b1;
							p_frame = 5'(idx_q);
							p_op    = cbfm_pkg::OP_WRITE_BACK;
							p_file  = rdata.file;
							p_page  = rdata.page;
							wbcnt_d = wbcnt_q + 6'd1;
						end
						mreq.we          = 1'b1;
						mreq.wdata.valid = 1'b0;
						mreq.wdata.refb  = 1'b0;
						mreq.wdata.dirty = 1'b0;
						mreq.wdata.pins  = '0;
						mreq.wdata.file  = '0;
					end
					if (idx_q == LAST_IDX) begin
						state_d = S_FIN;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_FRD;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					p_status  = cl_status_q;
					p_frame   = cl_frame_q;
					p_op      = cl_op_q;
					p_file    = cl_file_q;
					p_page    = cl_page_q;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			hand_q    <= LAST_IDX;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			hand_q  <= hand_d;
			if (push) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q   <= kind;
			file_q   <= file_id;
			page_q   <= page_number;
			mdirty_q <= mark_dirty;
		end
		idx_q       <= idx_d;
		step_q      <= step_d;
		wbcnt_q     <= wbcnt_d;
		cl_status_q <= cl_status_d;
		cl_frame_q  <= cl_frame_d;
		cl_op_q     <= cl_op_d;
		cl_file_q   <= cl_file_d;
		cl_page_q   <= cl_page_d;
		if (push) begin
			status      <= p_status;
			frame_index <= p_frame;
			disk_op     <= p_op;
			disk_file   <= p_file;
			disk_page   <= p_page;
			last        <= push_last;
		end
	end

	`CBFM_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_acc, in_stall)
	`CBFM_ASSERT_IMPL(a_no_rw_overlap, clk, arst_n, mreq.re, !mreq.we)
	`CBFM_ASSERT_IMPL(a_push_needs_room, clk, arst_n, push, out_free)
	`CBFM_ASSERT_IMPL(a_idle_no_access, clk, arst_n, state_q == S_IDLE,
		!mreq.re && !mreq.we && !push)

endmodule
